[rtl/core/hai_pkg.sv]
// ----------------------------------------------------------------------------
// hai_pkg
// shared constants and helpers for the hall angle interpolator
// ----------------------------------------------------------------------------
package hai_pkg;

	// register indexes on the config port (byte address = 4 * index)
	localparam logic [1:0] REG_ANGLE_OFFSET  = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
	localparam logic [1:0] REG_STALL_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_POSITION_STEP = 2'd3;

	// reset values
	localparam logic [15:0] DEBOUNCE_RST      = 16'd500;
	localparam logic [23:0] STALL_TIMEOUT_RST = 24'd500000;
	localparam logic [13:0] POSITION_STEP_RST = 14'd2194;
	localparam logic [31:0] DURATION_RST      = 32'd1000000;

	// angle arithmetic in units of 1/(6*65536) turn
	localparam int unsigned QUO_BITS   = 16;
	localparam logic signed [20:0] TURN_UNITS  = 21'sd393216;
	localparam logic [16:0]        SIXTH_UNITS = 17'd65536;
	// ceil(2^19 / 3), exact floor division by 3 for inputs below 2^19
	localparam logic [17:0] RECIP3 = 18'd174763;

	// hall position to sector base, in sixths of a turn
	function automatic logic [2:0] sector_of_pos(input logic [2:0] pos);
		logic [2:0] s;
		case (pos)
			3'd1: s = 3'd1;
			3'd2: s = 3'd0;
			3'd3: s = 3'd5;
			3'd4: s = 3'd4;
			3'd5: s = 3'd3;
			3'd6: s = 3'd2;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

[rtl/core/hai_in_if.sv]
// ----------------------------------------------------------------------------
// hai_in_if
// input channel: hall edge events and angle queries
// ----------------------------------------------------------------------------
interface hai_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] time_us;
	logic [2:0]  hall_state;
	logic signed [1:0] direction;

	modport source (output valid, action, time_us, hall_state, direction, input ready);
	modport sink (input valid, action, time_us, hall_state, direction, output ready);
endinterface

[rtl/core/hai_out_if.sv]
// ----------------------------------------------------------------------------
// hai_out_if
// result channel: edge acceptance, angle and position
// ----------------------------------------------------------------------------
interface hai_out_if;
	logic        valid;
	logic        ready;
	logic        edge_accepted;
	logic [15:0] angle;
	logic signed [31:0] position;

	modport source (output valid, edge_accepted, angle, position, input ready);
	modport sink (input valid, edge_accepted, angle, position, output ready);
endinterface

[rtl/core/hall_angle_interpolator.sv]
// ----------------------------------------------------------------------------
// hall_angle_interpolator
// hall edge debounce, sector timing, position count and interpolated angle
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                    beat content
//  --------  ----  ---------------------------  ---------------------------------
//  item      in    valid/ready                  action, time_us, hall_state,
//                                               direction
//  result    out   valid/ready                  edge_accepted, angle, position
//  apb       in    psel/penable/pwrite, pready  4 registers at 0x0, 0x4, 0x8, 0xc
//
//  an edge beat, or a query on an invalid hall state, runs through PREP and
//  DECIDE from accept to result valid, any other query also through SUM and
//  SCALE, and one that interpolates also through DIV, the restoring divider
//  (one 34-bit subtract/compare per quotient bit) that forms elapsed/duration
//  one beat at a time: item.ready is high only while idle
//  a result waits in its output register until taken; no new beat meanwhile
//  arst_n resets the sequencer, the timing state and the config registers
//
module hall_angle_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	hai_in_if.sink      item,
	hai_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hai_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1; // elapsed time
	localparam logic [2:0] ST_DECIDE = 3'd2; // debounce or interpolation mode
	localparam logic [2:0] ST_DIV    = 3'd3; // one quotient bit per cycle
	localparam logic [2:0] ST_SUM    = 3'd4; // base + offset +/- interp, wrap
	localparam logic [2:0] ST_SCALE  = 3'd5; // divide by 6 with rounding
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [15:0] angle_offset_q;
	logic [15:0] debounce_q;
	logic [23:0] stall_timeout_q;
	logic [13:0] position_step_q;

	// timing and position state
	logic [31:0] last_edge_time_q;
	logic [31:0] sector_duration_q;
	logic [31:0] pos_count_q;

	// captured beat
	logic        action_q;
	logic [31:0] time_q;
	logic [2:0]  hall_q;
	logic [1:0]  dir_q;

	// working registers
	logic [31:0] elapsed_q;
	logic [31:0] rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [3:0]  cnt_q;
	logic [16:0] interp_q;
	logic [18:0] sum_q;
	logic        accepted_q;
	logic [15:0] angle_q;

	// ------------------------------------------------------------------
	// config port: zero wait states, writes land in the access cycle
	// ------------------------------------------------------------------
	logic cfg_write;
	assign cfg_write = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_offset_q  <= '0;
			debounce_q      <= DEBOUNCE_RST;
			stall_timeout_q <= STALL_TIMEOUT_RST;
			position_step_q <= POSITION_STEP_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_ANGLE_OFFSET:  angle_offset_q  <= pwdata[15:0];
				REG_DEBOUNCE:      debounce_q      <= pwdata[15:0];
				REG_STALL_TIMEOUT: stall_timeout_q <= pwdata[23:0];
				REG_POSITION_STEP: position_step_q <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ANGLE_OFFSET:  prdata = {16'd0, angle_offset_q};
			REG_DEBOUNCE:      prdata = {16'd0, debounce_q};
			REG_STALL_TIMEOUT: prdata = {8'd0, stall_timeout_q};
			REG_POSITION_STEP: prdata = {18'd0, position_step_q};
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// shared divider step: shift remainder, trial subtract the duration
	// ------------------------------------------------------------------
	logic [33:0] div_shift;
	logic [33:0] div_diff;
	logic        div_bit;
	assign div_shift = {1'b0, rem_q, 1'b0};
	assign div_diff  = div_shift - {2'b00, sector_duration_q};
	assign div_bit   = !div_diff[33];

	// ------------------------------------------------------------------
	// angle sum in 1/393216 turn, wrapped to one turn, plus rounding bias
	// ------------------------------------------------------------------
	logic signed [20:0] base_s;
	logic signed [20:0] off_s;
	logic signed [20:0] off6_s;
	logic signed [20:0] interp_s;
	logic signed [20:0] total_s;
	logic signed [20:0] wrapped_s;
	always_comb begin
		base_s   = $signed({2'b00, sector_of_pos(hall_q), 16'd0});
		off_s    = $signed({{5{angle_offset_q[15]}}, angle_offset_q});
		off6_s   = (off_s <<< 2) + (off_s <<< 1);
		interp_s = $signed({4'd0, interp_q});
		total_s  = dir_q[1] ? (base_s + off6_s - interp_s) : (base_s + off6_s + interp_s);
		if (total_s < 0)
			wrapped_s = total_s + TURN_UNITS;
		else if (total_s >= TURN_UNITS)
			wrapped_s = total_s - TURN_UNITS;
		else
			wrapped_s = total_s;
	end

	// divide by 6: halve, then multiply by the reciprocal of 3
	logic [35:0] scale_prod;
	assign scale_prod = {18'd0, sum_q[18:1]} * {18'd0, RECIP3};

	logic        dir_nz;
	logic        pos_valid;
	logic [31:0] step_ext;
	assign dir_nz    = |dir_q;
	assign pos_valid = (hall_q != 3'd0) && (hall_q != 3'd7);
	assign step_ext  = {18'd0, position_step_q};

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			last_edge_time_q  <= '0;
			sector_duration_q <= DURATION_RST;
			pos_count_q       <= '0;
			cnt_q             <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item.valid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!action_q) begin
						// hall edge: debounce, retime, step the position
						if (elapsed_q >= {16'd0, debounce_q}) begin
							sector_duration_q <= elapsed_q;
							last_edge_time_q  <= time_q;
							if (dir_nz)
								pos_count_q <= dir_q[1] ?
									pos_count_q - step_ext :
									pos_count_q + step_ext;
						end
						state_q <= ST_OUT;
					end else if (!pos_valid) begin
						state_q <= ST_OUT;
					end else if (dir_nz && sector_duration_q != '0 &&
						elapsed_q <= {8'd0, stall_timeout_q} &&
						elapsed_q < sector_duration_q) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(QUO_BITS - 1)) state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (result.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				action_q <= item.action;
				time_q   <= item.time_us;
				hall_q   <= item.hall_state;
				dir_q    <= item.direction;
			end
			ST_PREP: begin
				elapsed_q <= time_q - last_edge_time_q;
			end
			ST_DECIDE: begin
				accepted_q <= !action_q && (elapsed_q >= {16'd0, debounce_q});
				angle_q    <= '0;
				rem_q      <= elapsed_q;
				quo_q      <= '0;
				// interpolation when no division is needed
				if (!dir_nz || sector_duration_q == '0 ||
					elapsed_q > {8'd0, stall_timeout_q})
					interp_q <= '0;
				else
					interp_q <= SIXTH_UNITS;
			end
			ST_DIV: begin
				rem_q <= div_bit ? div_diff[31:0] : div_shift[31:0];
				quo_q <= {quo_q[QUO_BITS-2:0], div_bit};
				if (cnt_q == 4'(QUO_BITS - 1))
					interp_q <= {1'b0, quo_q[QUO_BITS-2:0], div_bit};
			end
			ST_SUM: begin
				sum_q <= 19'(wrapped_s) + 19'd3;
			end
			ST_SCALE: begin
				angle_q <= scale_prod[34:19];
			end
			default: ;
		endcase
	end

	assign item.ready           = (state_q == ST_IDLE);
	assign result.valid         = (state_q == ST_OUT);
	assign result.edge_accepted = accepted_q;
	assign result.angle         = angle_q;
	assign result.position      = $signed(pos_count_q);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("input taken while a result is pending");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_SUM)
		else $error("divider left early");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < sector_duration_q)
		else $error("divider remainder out of range");

	a_edge_angle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.edge_accepted |-> result.angle == 16'd0)
		else $error("edge result carries an angle");

	a_pos_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> $stable(pos_count_q))
		else $error("position moved while a result waits");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hall angle interpolator: a clocked driver feeds
// edge and query beats from a queue, a clocked monitor compares every result
// beat against a rotor tracker kept in the bench, under changing register
// settings and several idle patterns on both channels
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hai_pkg::*;

	// beat kinds and direction codes as they appear on the input channel
	localparam logic       ACT_EDGE  = 1'b0;
	localparam logic       ACT_QUERY = 1'b1;
	localparam logic [1:0] DIR_NONE  = 2'b00;
	localparam logic [1:0] DIR_FWD   = 2'b01;
	localparam logic [1:0] DIR_REV2  = 2'b10;
	localparam logic [1:0] DIR_REV   = 2'b11;

	// angle units: 1/6 turn split into 2^16, whole turn is six of those
	localparam longint SIXTH = 65536;
	localparam longint TURN  = 393216;

	// slowest result path: PREP, DECIDE, the divider, SUM and SCALE, then the output register
	localparam int DRAIN_CYCLES = 24;
	localparam int MAX_REPORTS  = 10;

	// sector base in sixths of a turn, indexed by hall position
	localparam int SECTOR_BASE [8] = '{0, 1, 0, 5, 4, 3, 2, 0};

	typedef struct packed {
		logic        action;
		logic [31:0] time_us;
		logic [2:0]  hall;
		logic [1:0]  dir;
		logic        hold;      // wait until all results are back before sending
	} hall_beat_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] angle;
		logic [31:0] position;
	} rotor_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hai_in_if  in_ch ();
	hai_out_if out_ch ();

	hall_angle_interpolator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (in_ch),
		.result  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// beats waiting to be sent, and results the tracker predicts
	hall_beat_t    beats_to_send [$];
	rotor_result_t predicted_results [$];

	// register copy in the bench
	logic signed [15:0] cfg_offset;
	logic [15:0]        cfg_debounce;
	logic [23:0]        cfg_stall;
	logic [13:0]        cfg_step;

	// rotor timing state in the bench
	logic [31:0] last_edge_us;
	logic [31:0] sector_dur_us;
	logic [31:0] pos_count;

	// idle percentages for both channels, and driver status
	int unsigned send_idle;
	int unsigned recv_idle;
	bit          driver_busy;

	// stimulus time cursor
	logic [31:0] stim_now;

	int mismatches;
	int checked;
	int edges_taken;
	int edges_bounced;
	int queries;
	int queries_interp;
	int queries_stalled;

	// angle for a query beat; counts the interpolating and stalled cases
	function automatic logic [15:0] query_angle(input logic [31:0] now,
			input logic [2:0] hall, input int sgn);
		longint      total;
		longint      frac;
		logic [31:0] elapsed;
		if (hall == 3'd0 || hall == 3'd7)
			return 16'd0;
		total = longint'(SECTOR_BASE[hall]) * SIXTH + longint'(cfg_offset) * 6;
		// no interpolation when direction is unknown or the sector had zero length
		if (sgn != 0 && sector_dur_us != 32'd0) begin
			elapsed = now - last_edge_us;
			if (elapsed > {8'd0, cfg_stall}) begin
				frac = 0;
				queries_stalled++;
			end else if (elapsed >= sector_dur_us) begin
				frac = SIXTH;
			end else begin
				frac = longint'((64'(elapsed) * 64'(SIXTH)) / 64'(sector_dur_us));
				queries_interp++;
			end
			total += (sgn > 0) ? frac : -frac;
		end
		total = total % TURN;
		if (total < 0)
			total += TURN;
		// round to nearest Q16, ties upward
		return 16'((total + 3) / 6);
	endfunction

	// advances the tracker by one accepted beat and returns its result
	function automatic rotor_result_t rotor_track(input hall_beat_t b);
		rotor_result_t r;
		logic [31:0]   gap;
		int            sgn;
		r = '0;
		case (b.dir)
			DIR_FWD: sgn = 1;
			DIR_NONE: sgn = 0;
			default: sgn = -1;     // both negative codes run in reverse
		endcase
		if (b.action == ACT_EDGE) begin
			gap = b.time_us - last_edge_us;
			if (gap >= {16'd0, cfg_debounce}) begin
				sector_dur_us = gap;
				last_edge_us = b.time_us;
				if (sgn > 0)
					pos_count += {18'd0, cfg_step};
				else if (sgn < 0)
					pos_count -= {18'd0, cfg_step};
				r.accepted = 1'b1;
				edges_taken++;
			end else begin
				edges_bounced++;
			end
		end else begin
			r.angle = query_angle(b.time_us, b.hall, sgn);
			queries++;
		end
		r.position = pos_count;
		return r;
	endfunction

	// driver: one beat on the wire at a time, valid held until ready
	always @(posedge clk or negedge arst_n) begin
		hall_beat_t sent;
		hall_beat_t nxt;
		bit         launch;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.action <= ACT_EDGE;
			in_ch.time_us <= '0;
			in_ch.hall_state <= '0;
			in_ch.direction <= '0;
			driver_busy = 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				sent = '0;
				sent.action = in_ch.action;
				sent.time_us = in_ch.time_us;
				sent.hall = in_ch.hall_state;
				sent.dir = in_ch.direction;
				predicted_results.push_back(rotor_track(sent));
			end
			if (in_ch.valid && !in_ch.ready) begin
				// beat still waiting, leave it on the wire
				driver_busy = 1'b1;
			end else begin
				launch = 1'b0;
				if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					// a hold beat waits for the result channel to drain
					if (!beats_to_send[0].hold || predicted_results.size() == 0)
						launch = 1'b1;
				end
				if (launch) begin
					nxt = beats_to_send.pop_front();
					in_ch.action <= nxt.action;
					in_ch.time_us <= nxt.time_us;
					in_ch.hall_state <= nxt.hall;
					in_ch.direction <= nxt.dir;
				end
				in_ch.valid <= launch;
				driver_busy = launch;
			end
		end
	end

	// monitor: compares each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		rotor_result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%t unexpected result beat: acc=%0d angle=%0d pos=%0d",
							$realtime, out_ch.edge_accepted, out_ch.angle, out_ch.position);
				end else begin
					want = predicted_results.pop_front();
					checked++;
					if (out_ch.edge_accepted !== want.accepted || out_ch.angle !== want.angle
							|| out_ch.position !== want.position) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%t mismatch: expected acc=%0d angle=%0d pos=%0d, got acc=%0d angle=%0d pos=%0d",
								$realtime, want.accepted, want.angle, $signed(want.position),
								out_ch.edge_accepted, out_ch.angle, out_ch.position);
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic push_beat(input logic act, input logic [31:0] t, input logic [2:0] hall,
			input logic [1:0] dir, input logic hold);
		hall_beat_t b;
		b.action = act;
		b.time_us = t;
		b.hall = hall;
		b.dir = dir;
		b.hold = hold;
		beats_to_send.push_back(b);
	endtask

	// apb write: setup cycle, then access cycle; register updates on the access edge
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ANGLE_OFFSET: cfg_offset = val[15:0];
			REG_DEBOUNCE: cfg_debounce = val[15:0];
			REG_STALL_TIMEOUT: cfg_stall = val[23:0];
			REG_POSITION_STEP: cfg_step = val[13:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] off, input logic [15:0] dbc,
			input logic [23:0] stall, input logic [13:0] step);
		write_reg(REG_ANGLE_OFFSET, {16'd0, off});
		write_reg(REG_DEBOUNCE, {16'd0, dbc});
		write_reg(REG_STALL_TIMEOUT, {8'd0, stall});
		write_reg(REG_POSITION_STEP, {18'd0, step});
	endtask

	// block until every beat is sent and answered, then let the pipeline settle
	task automatic wait_idle();
		while (beats_to_send.size() != 0 || driver_busy || predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random beats along a rough rotor timeline with sector length near nom_us
	task automatic queue_random(input int count, input int nom_us);
		int          r;
		int          gap;
		logic [2:0]  hall;
		logic [31:0] noise_t;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				// hall edge: mostly sector-like spacing, some near or under debounce
				r = $urandom_range(0, 99);
				if (r < 70)
					gap = $urandom_range(nom_us / 2, nom_us * 3 / 2);
				else if (r < 85)
					gap = int'(cfg_debounce) + int'($urandom_range(0, 4)) - 2;
				else if (r < 95)
					gap = $urandom_range(0, cfg_debounce);
				else
					gap = $urandom_range(nom_us, nom_us * 8);
				if (gap < 0)
					gap = 0;
				stim_now += gap;
				push_beat(ACT_EDGE, stim_now, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					$urandom_range(0, 99) == 0);
			end else if (r < 92) begin
				// angle query somewhere in the current sector, sometimes long after
				if ($urandom_range(0, 19) == 0)
					gap = $urandom_range(nom_us, nom_us * 4);
				else
					gap = $urandom_range(0, nom_us / 3);
				stim_now += gap;
				hall = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 1) * 7)
					: 3'($urandom_range(1, 6));
				push_beat(ACT_QUERY, stim_now, hall, 2'($urandom_range(0, 3)),
					$urandom_range(0, 99) == 0);
			end else begin
				// noise: any timestamp, any field; the timeline may jump there
				noise_t = $urandom;
				push_beat(1'($urandom_range(0, 1)), noise_t, 3'($urandom_range(0, 7)),
					2'($urandom_range(0, 3)), 1'b0);
				if ($urandom_range(0, 1) == 1)
					stim_now = noise_t;
			end
		end
	endtask

	initial begin
		int nom_us;

		// apb inputs known from time zero, the channels start in the driver and monitor
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		cfg_offset = '0;
		cfg_debounce = DEBOUNCE_RST;
		cfg_stall = STALL_TIMEOUT_RST;
		cfg_step = POSITION_STEP_RST;
		last_edge_us = '0;
		sector_dur_us = DURATION_RST;
		pos_count = '0;
		mismatches = 0;
		checked = 0;
		edges_taken = 0;
		edges_bounced = 0;
		queries = 0;
		queries_interp = 0;
		queries_stalled = 0;
		send_idle = 9;
		recv_idle = 46;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats on the reset settings
		push_beat(ACT_QUERY, 32'd0, 3'd1, DIR_NONE, 1'b0);        // plain sector base
		push_beat(ACT_QUERY, 32'd10, 3'd0, DIR_FWD, 1'b0);        // invalid position
		push_beat(ACT_QUERY, 32'd10, 3'd7, DIR_REV, 1'b0);        // invalid position
		push_beat(ACT_QUERY, 32'd250000, 3'd2, DIR_FWD, 1'b0);    // quarter sector forward
		push_beat(ACT_QUERY, 32'd600000, 3'd3, DIR_REV, 1'b0);    // past stall timeout
		push_beat(ACT_QUERY, 32'd400000, 3'd4, DIR_REV2, 1'b0);   // code -2 runs reverse
		push_beat(ACT_EDGE, 32'd100, 3'd1, DIR_FWD, 1'b0);        // bounced edge
		push_beat(ACT_EDGE, 32'd500, 3'd1, DIR_FWD, 1'b0);        // exactly at debounce
		push_beat(ACT_QUERY, 32'd750, 3'd5, DIR_FWD, 1'b0);       // half sector
		push_beat(ACT_QUERY, 32'd1000, 3'd6, DIR_FWD, 1'b1);      // full sector, drained first
		push_beat(ACT_EDGE, 32'd1200, 3'd6, DIR_NONE, 1'b0);      // timed, position kept
		push_beat(ACT_EDGE, 32'd2000, 3'd5, DIR_REV, 1'b0);
		push_beat(ACT_EDGE, 32'd2500, 3'd4, DIR_REV2, 1'b0);
		push_beat(ACT_EDGE, 32'd3100, 3'd7, DIR_FWD, 1'b0);       // hall ignored on edges
		push_beat(ACT_QUERY, 32'd3100, 3'd1, DIR_FWD, 1'b0);      // zero elapsed
		push_beat(ACT_QUERY, 32'd3150, 3'd2, DIR_REV, 1'b0);      // reverse below base
		push_beat(ACT_EDGE, 32'hFFFF_FF00, 3'd3, DIR_FWD, 1'b0);  // near the timestamp wrap
		push_beat(ACT_EDGE, 32'h0000_0100, 3'd3, DIR_FWD, 1'b0);  // across the wrap
		push_beat(ACT_QUERY, 32'h0000_0180, 3'd4, DIR_FWD, 1'b0);
		push_beat(ACT_QUERY, 32'hFFFF_FFFF, 3'd6, DIR_REV, 1'b0); // huge elapsed, stalled
		wait_idle();

		stim_now = 32'd5000;
		for (int ph = 1; ph <= 5; ph++) begin
			// receiver-heavy stalls first, then sender gaps, then full rate
			if (ph >= 4) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (ph >= 2) begin
				send_idle = 46;
				recv_idle = 9;
			end
			case (ph)
				1: begin
					// most negative offset, no debounce, longest timeout, step 15360
					apply_settings(16'h8000, 16'd0, 24'hFF_FFFF, 14'd15360);
					nom_us = 2000;
					// equal edge times give a zero-length sector
					push_beat(ACT_EDGE, stim_now, 3'd1, DIR_FWD, 1'b0);
					push_beat(ACT_EDGE, stim_now, 3'd1, DIR_REV, 1'b0);
					push_beat(ACT_QUERY, stim_now + 32'd7, 3'd2, DIR_REV, 1'b0);
					push_beat(ACT_QUERY, stim_now + 32'd7, 3'd3, DIR_FWD, 1'b0);
					push_beat(ACT_QUERY, stim_now + 32'd7, 3'd1, DIR_NONE, 1'b0);
				end
				2: begin
					// largest offset and debounce, zero timeout and step
					apply_settings(16'h7FFF, 16'hFFFF, 24'd0, 14'd0);
					nom_us = 80000;
				end
				3: begin
					// short timeout so stalls are common
					apply_settings(16'($urandom), 16'd300, 24'd5000,
						14'($urandom_range(0, 15360)));
					nom_us = 4000;
				end
				4: begin
					apply_settings(16'($urandom), 16'($urandom_range(0, 2000)),
						24'($urandom_range(0, 24'hFF_FFFF)), 14'($urandom_range(0, 15360)));
					nom_us = int'(cfg_debounce) + 1000;
					stim_now = 32'hFFF0_0000 + $urandom_range(0, 65535);   // run through the wrap
				end
				default: begin
					apply_settings(16'($urandom), DEBOUNCE_RST, STALL_TIMEOUT_RST,
						POSITION_STEP_RST);
					nom_us = 20000;
				end
			endcase
			queue_random(250, nom_us);
			wait_idle();
		end

		// leftover predictions mean results never came
		if (predicted_results.size() != 0)
			mismatches += predicted_results.size();

		$display("run covered %0d edges (%0d accepted, %0d bounced) and %0d queries",
			edges_taken + edges_bounced, edges_taken, edges_bounced, queries);
		$display("  %0d interpolated, %0d stalled; %0d results checked over 6 settings",
			queries_interp, queries_stalled, checked);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
rtl/core/hai_pkg.sv
rtl/core/hai_in_if.sv
rtl/core/hai_out_if.sv
rtl/core/hall_angle_interpolator.sv
bench/tb_top.sv
